/* design/best_fit_block_allocator_macros.svh */
// ----------------------------------------------------------------------------
// best_fit_block_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define BFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication, disabled in reset
`define BFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

/* design/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int unsigned NUM_BLOCKS = 16;
  localparam int unsigned SIZE_WIDTH = 16;
  localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_ACTIVE_BLOCKS = 1'b0,
    REG_NONE          = 1'b1
  } reg_idx_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [3:0]            block_index;
    logic [SIZE_WIDTH-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [3:0]            granted_block;
    logic [SIZE_WIDTH-1:0] left_over;
  } out_item_t;

  // search item moving down the cell chain
  typedef struct packed {
    logic                  valid;
    logic [SIZE_WIDTH-1:0] amount;
    logic                  hit;
    logic [SIZE_WIDTH-1:0] best_size;
    logic [IDX_W-1:0]      best_idx;
  } token_t;

  // shared write port into the cells
  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      idx;
    logic [SIZE_WIDTH-1:0] data;
  } wr_t;

endpackage

`default_nettype wire

/* design/bfa_cell.sv */
// ----------------------------------------------------------------------------
// bfa_cell
// One table entry: holds a block size and folds it into the passing search.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [bfa_pkg::IDX_W-1:0] cell_idx_i,
  input  wire logic [bfa_pkg::CNT_W-1:0] active_blocks_i,
  input  wire logic                  en_i,
  input  wire bfa_pkg::wr_t          wr_i,
  input  wire bfa_pkg::token_t       tok_i,
  output bfa_pkg::token_t            tok_o
);
  import bfa_pkg::*;

  logic [SIZE_WIDTH-1:0] size_q;
  logic                  tok_valid_q;
  token_t                tok_q, tok_d;
  logic                  active, fit;

  assign active = {1'b0, cell_idx_i} < active_blocks_i;
  assign fit    = active && (size_q >= tok_i.amount) &&
                  (!tok_i.hit || (size_q < tok_i.best_size));

  always_comb begin
    tok_d = tok_i;
    if (fit) begin
      tok_d.hit       = 1'b1;
      tok_d.best_size = size_q;
      tok_d.best_idx  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      size_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else if (en_i) begin
      tok_valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

`default_nettype wire

/* design/bfa_regs.sv */
// ----------------------------------------------------------------------------
// bfa_regs
// APB register file holding the active block count.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bfa_pkg::APB_AW-1:0] paddr,
  input  wire logic [bfa_pkg::APB_DW-1:0] pwdata,
  output logic      [bfa_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output logic      [bfa_pkg::CNT_W-1:0]  active_blocks_o
);
  import bfa_pkg::*;

  logic [CNT_W-1:0] active_blocks_q;
  reg_idx_e         reg_sel;

  assign reg_sel = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_blocks_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (reg_sel == REG_ACTIVE_BLOCKS)) begin
      active_blocks_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ACTIVE_BLOCKS: prdata = APB_DW'(active_blocks_q);
      default:           prdata = '0;
    endcase
  end

  assign active_blocks_o = active_blocks_q;

endmodule

`default_nettype wire

/* design/best_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a chain of size cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i) takes load and allocate
//   items. A load writes one block size and is done in its accept cycle.
//   An allocate item walks the 16-cell chain, one cell per cycle; each cell
//   compares its own size and passes the best candidate on. After the last
//   cell the winner is reduced by the request and the result is registered.
//   A new allocate item is accepted only after the current search is done;
//   loads are taken back to back while no search runs.
//   Output channel (out_valid_o/out_ready_i, out_item_o) holds one result.
//   If it stalls, a finished search waits at the chain end and the next
//   request may still be accepted once the previous result is registered.
//   Reset clears the control state and the active block count; block sizes
//   must be loaded before they take part in a search.
//   The APB port writes active_blocks at address 0; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "best_fit_block_allocator_macros.svh"

module best_fit_block_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire bfa_pkg::in_item_t          in_item_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output bfa_pkg::out_item_t              out_item_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bfa_pkg::APB_AW-1:0] paddr,
  input  wire logic [bfa_pkg::APB_DW-1:0] pwdata,
  output logic      [bfa_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import bfa_pkg::*;

  logic [CNT_W-1:0]      active_blocks;
  token_t                tok [NUM_BLOCKS+1];
  logic [NUM_BLOCKS-1:0] tok_valid_vec;
  token_t                tok_last;
  wr_t                   wr;
  logic                  accept, load_acc, alloc_acc;
  logic                  chain_en, done;
  logic                  busy_q;
  logic                  out_valid_q;
  out_item_t             out_item_q;

  bfa_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .active_blocks_o (active_blocks)
  );

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign load_acc   = accept && (in_item_i.opcode == OP_LOAD);
  assign alloc_acc  = accept && (in_item_i.opcode == OP_ALLOC);

  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = alloc_acc;
    tok[0].amount    = in_item_i.amount;
  end

  assign tok_last = tok[NUM_BLOCKS];
  assign chain_en = !(tok_last.valid && out_valid_q && !out_ready_i);
  assign done     = tok_last.valid && chain_en;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    bfa_cell u_cell (
      .clk_i,
      .rst_ni,
      .cell_idx_i      (IDX_W'(g)),
      .active_blocks_i (active_blocks),
      .en_i            (chain_en),
      .wr_i            (wr),
      .tok_i           (tok[g]),
      .tok_o           (tok[g+1])
    );
    assign tok_valid_vec[g] = tok[g+1].valid;
  end

  always_comb begin
    wr = '0;
    if (load_acc) begin
      wr.en   = 1'b1;
      wr.idx  = in_item_i.block_index;
      wr.data = in_item_i.amount;
    end else if (done && tok_last.hit) begin
      wr.en   = 1'b1;
      wr.idx  = tok_last.best_idx;
      wr.data = tok_last.best_size - tok_last.amount;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (alloc_acc) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_item_q.found         <= tok_last.hit;
      out_item_q.granted_block <= tok_last.hit ? tok_last.best_idx : '0;
      out_item_q.left_over     <= tok_last.hit ?
                                  (tok_last.best_size - tok_last.amount) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `BFA_ASSERT_IMP(a_one_search, clk_i, rst_ni, 1'b1, $onehot0(tok_valid_vec))
  `BFA_ASSERT_IMP(a_idle_chain_empty, clk_i, rst_ni, !busy_q, tok_valid_vec == '0)
  `BFA_ASSERT_NXT(a_alloc_busy, clk_i, rst_ni, alloc_acc, busy_q && tok_valid_vec[0])
  `BFA_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, out_valid_o && !out_item_o.found, out_item_o.granted_block == '0 && out_item_o.left_over == '0)

endmodule

`default_nettype wire
